// ----- src/ccd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants of the clock and countdown timer
// Time-of-day and countdown values, function codes, register indexes and
// the limits of each time field.
// ----------------------------------------------------------------------------
package ccd_pkg;

   // Function codes of an input item (code 3 is unused and changes nothing)
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_STOP  = 2'd2
   } func_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_SYNC_INTERVAL = 3'd0;
   localparam logic [2:0] CSR_USE_24_HOUR   = 3'd1;
   localparam logic [2:0] CSR_TIMER_HOURS   = 3'd2;
   localparam logic [2:0] CSR_TIMER_MINUTES = 3'd3;
   localparam logic [2:0] CSR_TIMER_SECONDS = 3'd4;
   localparam logic [2:0] CSR_WINDOW_START  = 3'd5;
   localparam logic [2:0] CSR_WINDOW_END    = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   // Reset values of the registers that are not zero
   localparam logic [15:0] SYNC_INTERVAL_RESET = 16'd3600;
   localparam logic        USE_24_HOUR_RESET   = 1'b1;

   // Field limits
   localparam logic [5:0] SEC_MAX         = 6'd59;
   localparam logic [5:0] MIN_MAX         = 6'd59;
   localparam logic [4:0] CLOCK_HOUR_MAX  = 5'd23;
   localparam logic [4:0] TIMER_HOUR_MAX  = 5'd24;
   localparam logic [4:0] PM_HOUR_FIRST   = 5'd13;
   localparam logic [4:0] HALF_DAY_HOURS  = 5'd12;

   // Seconds-of-day weights
   localparam logic [16:0] SECONDS_PER_HOUR   = 17'd3600;
   localparam logic [16:0] SECONDS_PER_MINUTE = 17'd60;

   // Hours, minutes, seconds
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } hms_type;

   // Countdown status for one item
   typedef struct packed {
      logic running;
      logic tick;
      logic done;
   } cd_status_type;

endpackage

// ----- src/ccd_clock.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_clock: time-of-day clock with reference-time loading
// Holds hours, minutes, seconds and the sync counter. A tick item either
// loads the reference time (counter due and reference valid) or advances
// the clock by one second. Shows the time as it stands after the item.
// ----------------------------------------------------------------------------
module ccd_clock (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             tick,
   input  logic             sync_ok,
   input  ccd_pkg::hms_type sync_time,
   input  logic [15:0]      sync_interval,
   output ccd_pkg::hms_type time_now,
   output logic             synced
);

   ccd_pkg::hms_type time_ff, time_in, time_adv;
   logic [15:0]      counter_ff, counter_in, counter_inc;
   logic             due;

   // One-second advance with wrap of every field
   always_comb begin
      time_adv = time_ff;
      time_adv.seconds = time_ff.seconds + 6'd1;
      if (time_adv.seconds > ccd_pkg::SEC_MAX) begin
         time_adv.seconds = 6'd0;
         time_adv.minutes = time_ff.minutes + 6'd1;
      end
      if (time_adv.minutes > ccd_pkg::MIN_MAX) begin
         time_adv.minutes = 6'd0;
         time_adv.hours   = time_ff.hours + 5'd1;
      end
      if (time_adv.hours > ccd_pkg::CLOCK_HOUR_MAX) begin
         time_adv.hours = 5'd0;
      end
   end

   // Sync counter saturates at all ones
   assign due         = counter_ff >= sync_interval;
   assign counter_inc = (counter_ff != '1) ? counter_ff + 16'd1 : counter_ff;

   // Next state for a tick item
   always_comb begin
      time_in    = time_ff;
      counter_in = counter_ff;
      synced     = 1'b0;
      if (tick) begin
         if (due && sync_ok) begin
            time_in    = sync_time;
            counter_in = '0;
            synced     = 1'b1;
         end else begin
            time_in    = time_adv;
            counter_in = counter_inc;
         end
      end
   end

   assign time_now = time_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         counter_ff <= '0;
      end else if (enable) begin
         time_ff    <= time_in;
         counter_ff <= counter_in;
      end
   end

endmodule

// ----- src/ccd_countdown.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_countdown: countdown timer with start, stop and auto reload
// Decrements the remaining time on each tick while running; at zero it
// flags done, reloads the duration and stops. A duration write reloads.
// ----------------------------------------------------------------------------
module ccd_countdown (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  ccd_pkg::func_type      func,
   input  ccd_pkg::hms_type       duration,
   input  logic                   load,
   output ccd_pkg::hms_type       remain_now,
   output ccd_pkg::cd_status_type status
);

   ccd_pkg::hms_type remain_ff, remain_in, remain_dec;
   logic             running_ff, running_in;

   // One-second decrement with borrow and clamping
   always_comb begin
      remain_dec = remain_ff;
      remain_dec.seconds = remain_ff.seconds - 6'd1;
      if (remain_dec.seconds > ccd_pkg::SEC_MAX) begin
         remain_dec.seconds = ccd_pkg::SEC_MAX;
         remain_dec.minutes = remain_ff.minutes - 6'd1;
      end
      if (remain_dec.minutes > ccd_pkg::MIN_MAX) begin
         remain_dec.minutes = ccd_pkg::MIN_MAX;
         remain_dec.hours   = remain_ff.hours - 5'd1;
      end
      if (remain_dec.hours > ccd_pkg::TIMER_HOUR_MAX) begin
         remain_dec.hours = ccd_pkg::TIMER_HOUR_MAX;
      end
   end

   // Next state per function code
   always_comb begin
      remain_in   = remain_ff;
      running_in  = running_ff;
      status.tick = 1'b0;
      status.done = 1'b0;
      if (load) begin
         remain_in = duration;
      end else begin
         case (func)
            ccd_pkg::FUNC_TICK: begin
               if (running_ff) begin
                  remain_in   = remain_dec;
                  status.tick = 1'b1;
                  if (remain_dec == '0) begin
                     status.done = 1'b1;
                     remain_in   = duration;
                     running_in  = 1'b0;
                  end
               end
            end
            ccd_pkg::FUNC_START: running_in = 1'b1;
            ccd_pkg::FUNC_STOP:  running_in = 1'b0;
            default: ;
         endcase
      end
      status.running = running_in;
   end

   assign remain_now = remain_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff  <= '0;
         running_ff <= 1'b0;
      end else if (enable || load) begin
         remain_ff  <= remain_in;
         running_ff <= running_in;
      end
   end

endmodule

// ----- src/clock_countdown_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_countdown_timer: time-of-day clock with countdown timer
// Top level: configuration registers, input register, clock and countdown
// units, display selection, window check and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a one-second tick, countdown start or stop,
//   plus the reference time sampled on a tick. Every item gives exactly one
//   result on rsp_*: the shown time, countdown flags, sync flag and the
//   active-window flag.
//   An accepted item sits in the input register while the clock and
//   countdown update, and moves into the result register, which drives
//   rsp_valid, once the result slot is free. Throughput is one item per
//   cycle, limited only by the result register draining.
//   When rsp_ready is low, the result holds, the input register holds one
//   more item, and req_ready falls until the result is taken.
//   csr_* writes a register by index (always ready); write only while idle.
//   A write to a duration register reloads the remaining countdown.
//   Reset (synchronous) clears clock, sync counter, countdown and both
//   register stages; sync interval returns to 3600, 24-hour display is on.
// ----------------------------------------------------------------------------
module clock_countdown_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic        req_sync_ok,
   input  logic [4:0]  req_sync_hours,
   input  logic [5:0]  req_sync_minutes,
   input  logic [5:0]  req_sync_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_shown_hours,
   output logic [5:0]  rsp_shown_minutes,
   output logic [5:0]  rsp_shown_seconds,
   output logic        rsp_countdown_running,
   output logic        rsp_countdown_tick,
   output logic        rsp_countdown_done,
   output logic        rsp_synced,
   output logic        rsp_in_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ccd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccd_pkg::CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers
   logic [15:0]      interval_ff, interval_in;
   logic             fmt24_ff, fmt24_in;
   ccd_pkg::hms_type dur_ff, dur_in;
   logic [16:0]      wstart_ff, wstart_in, wend_ff, wend_in;
   logic             csr_wr, dur_load;

   // Input stage
   logic             s1_valid_ff, s1_valid_in;
   logic [1:0]       s1_func_ff;
   logic             s1_ok_ff;
   ccd_pkg::hms_type s1_sync_ff;
   logic             req_take, adv;

   // Unit results
   ccd_pkg::hms_type       clk_time, remain_now, shown;
   ccd_pkg::cd_status_type cd_status;
   logic                   synced;
   logic [16:0]            now_sec;
   logic                   in_window;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   ccd_pkg::hms_type       rsp_shown_ff;
   ccd_pkg::cd_status_type rsp_status_ff;
   logic                   rsp_synced_ff, rsp_window_ff;

   // Configuration write decode
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      interval_in = interval_ff;
      fmt24_in    = fmt24_ff;
      dur_in      = dur_ff;
      wstart_in   = wstart_ff;
      wend_in     = wend_ff;
      dur_load    = 1'b0;
      if (csr_wr) begin
         case (csr_index)
            ccd_pkg::CSR_SYNC_INTERVAL: interval_in = csr_data[15:0];
            ccd_pkg::CSR_USE_24_HOUR:   fmt24_in    = csr_data[0];
            ccd_pkg::CSR_TIMER_HOURS: begin
               dur_in.hours = csr_data[4:0];
               dur_load     = 1'b1;
            end
            ccd_pkg::CSR_TIMER_MINUTES: begin
               dur_in.minutes = csr_data[5:0];
               dur_load       = 1'b1;
            end
            ccd_pkg::CSR_TIMER_SECONDS: begin
               dur_in.seconds = csr_data[5:0];
               dur_load       = 1'b1;
            end
            ccd_pkg::CSR_WINDOW_START:  wstart_in = csr_data;
            ccd_pkg::CSR_WINDOW_END:    wend_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= ccd_pkg::SYNC_INTERVAL_RESET;
         fmt24_ff    <= ccd_pkg::USE_24_HOUR_RESET;
         dur_ff      <= '0;
         wstart_ff   <= '0;
         wend_ff     <= '0;
      end else begin
         interval_ff <= interval_in;
         fmt24_ff    <= fmt24_in;
         dur_ff      <= dur_in;
         wstart_ff   <= wstart_in;
         wend_ff     <= wend_in;
      end
   end

   // Handshake: the input register moves on when the result slot is free
   assign adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || adv;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff         <= req_func;
         s1_ok_ff           <= req_sync_ok;
         s1_sync_ff.hours   <= req_sync_hours;
         s1_sync_ff.minutes <= req_sync_minutes;
         s1_sync_ff.seconds <= req_sync_seconds;
      end
   end

   // Clock unit
   ccd_clock u_clock (
      .clock         (clock),
      .reset         (reset),
      .enable        (adv),
      .tick          (s1_func_ff == ccd_pkg::FUNC_TICK),
      .sync_ok       (s1_ok_ff),
      .sync_time     (s1_sync_ff),
      .sync_interval (interval_ff),
      .time_now      (clk_time),
      .synced        (synced)
   );

   // Countdown unit
   ccd_countdown u_countdown (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .func       (ccd_pkg::func_type'(s1_func_ff)),
      .duration   (dur_in),
      .load       (dur_load),
      .remain_now (remain_now),
      .status     (cd_status)
   );

   // Shown time: countdown while running, else the clock in chosen format
   always_comb begin
      if (cd_status.running) begin
         shown = remain_now;
      end else begin
         shown = clk_time;
         if (!fmt24_ff && clk_time.hours >= ccd_pkg::PM_HOUR_FIRST) begin
            shown.hours = clk_time.hours - ccd_pkg::HALF_DAY_HOURS;
         end
      end
   end

   // Window check on seconds of day, wrapping past midnight
   assign now_sec = 17'(17'(clk_time.hours) * ccd_pkg::SECONDS_PER_HOUR)
                  + 17'(17'(clk_time.minutes) * ccd_pkg::SECONDS_PER_MINUTE)
                  + 17'(clk_time.seconds);

   always_comb begin
      if (wstart_ff > wend_ff) begin
         in_window = (now_sec >= wstart_ff) || (now_sec <= wend_ff);
      end else begin
         in_window = (now_sec >= wstart_ff) && (now_sec <= wend_ff);
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_shown_ff  <= shown;
         rsp_status_ff <= cd_status;
         rsp_synced_ff <= synced;
         rsp_window_ff <= in_window;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_shown_hours       = rsp_shown_ff.hours;
   assign rsp_shown_minutes     = rsp_shown_ff.minutes;
   assign rsp_shown_seconds     = rsp_shown_ff.seconds;
   assign rsp_countdown_running = rsp_status_ff.running;
   assign rsp_countdown_tick    = rsp_status_ff.tick;
   assign rsp_countdown_done    = rsp_status_ff.done;
   assign rsp_synced            = rsp_synced_ff;
   assign rsp_in_window         = rsp_window_ff;

endmodule

// ----- src/ccd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_checker: port-level checks for the clock and countdown timer
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module ccd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_shown_hours,
   input logic [5:0] rsp_shown_minutes,
   input logic [5:0] rsp_shown_seconds,
   input logic       rsp_countdown_running,
   input logic       rsp_countdown_tick,
   input logic       rsp_countdown_done,
   input logic       rsp_synced,
   input logic       rsp_in_window
);

   // A stalled item holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_shown_hours) && $stable(rsp_shown_minutes)
         && $stable(rsp_shown_seconds) && $stable(rsp_countdown_running)
         && $stable(rsp_countdown_tick) && $stable(rsp_countdown_done)
         && $stable(rsp_synced) && $stable(rsp_in_window))
      else $error("result item changed while stalled");

   // Done only comes with a decrement, and the countdown is stopped after it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_countdown_done |-> rsp_countdown_tick && !rsp_countdown_running)
      else $error("countdown done without tick or still running");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A decrement only happens while the countdown was running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_countdown_tick && !rsp_countdown_done |-> rsp_countdown_running)
      else $error("countdown ticked but not running");

endmodule

bind clock_countdown_timer ccd_checker u_ccd_checker (.*);
